/* rtl/stdf_pkg.sv */
package stdf_pkg;

  localparam int MAX_SEGMENTS_DEF = 1024;
  localparam int IN_Q_DEPTH       = 4;
  localparam int OUT_Q_DEPTH      = 2;

  localparam logic [27:0] SIZE_LIMIT = 28'hFFF_FFFF;

  localparam logic [2:0] ST_HEADER   = 3'd0;
  localparam logic [2:0] ST_PAYLOAD  = 3'd1;
  localparam logic [2:0] ST_DONE     = 3'd2;
  localparam logic [2:0] ST_TOO_MANY = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_TRUNC    = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       input_ends;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  payload_byte;
    logic [9:0]  segment_index;
    logic [30:0] offset_in_segment;
    logic        segment_end;
    logic        size_ready;
    logic [27:0] segment_words;
  } out_item_t;

endpackage

/* rtl/segment_table_deframer_core.sv */
// Stream-framing decoder for unpacked segmented messages, one byte per item
// in and exactly one result item out for each. Header bytes (count word, size
// words, padding word) and payload bytes are taken from the input queue while
// the output queue has room. Each segment start passes through the PH_LOAD and
// PH_CHECK states, repeating PH_CHECK for each empty segment skipped, for the
// registered read of the size table; a small input queue absorbs these gaps.
// Results show up on the output queue the cycle after their byte is consumed.
module segment_table_deframer_core #(
  parameter int MAX_SEGMENTS = stdf_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  stdf_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output stdf_pkg::out_item_t out_item
);
  import stdf_pkg::*;

  logic      head_valid, head_pop;
  in_item_t  head_item;
  out_item_t res_item;
  logic      res_push, res_full;

  stdf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pop   (head_pop)
  );

  stdf_engine #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (head_valid),
    .in_head  (head_item),
    .in_pop   (head_pop),
    .res_item (res_item),
    .res_push (res_push),
    .res_full (res_full)
  );

  stdf_out_queue u_out_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_item (res_item),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

/* rtl/stdf_front.sv */
module stdf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  stdf_pkg::in_item_t in_item,
  output logic               head_valid,
  output stdf_pkg::in_item_t head_item,
  input  logic               head_pop
);
  import stdf_pkg::*;

  localparam int PW = (IN_Q_DEPTH > 1) ? $clog2(IN_Q_DEPTH) : 1;
  localparam int CW = $clog2(IN_Q_DEPTH + 1);

  in_item_t        q_r [IN_Q_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full       = (cnt_r == CW'(IN_Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = q_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(IN_Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(IN_Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/stdf_engine.sv */
module stdf_engine #(
  parameter int MAX_SEGMENTS = stdf_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  stdf_pkg::in_item_t  in_head,
  output logic                in_pop,
  output stdf_pkg::out_item_t res_item,
  output logic                res_push,
  input  logic                res_full
);
  import stdf_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_SIZES = 3'd1;
  localparam logic [2:0] PH_LOAD  = 3'd2;
  localparam logic [2:0] PH_CHECK = 3'd3;
  localparam logic [2:0] PH_PAY   = 3'd4;

  logic [2:0]       phase_r, phase_nxt;
  logic [23:0]      asm_r, asm_nxt;
  logic [1:0]       biw_r, biw_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] wcnt_r, wcnt_nxt;
  logic [31:0]      total_r, total_nxt;
  logic [CNT_W-1:0] cur_r, cur_nxt;
  logic [30:0]      off_r, off_nxt;
  logic [30:0]      segb_r, segb_nxt;

  logic [27:0]      mem [MAX_SEGMENTS];
  logic [27:0]      rd_data_r;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [27:0]      wr_data;

  logic             step, word_done, done, err, restart;
  logic [31:0]      word;
  logic [32:0]      sum;
  logic [31:0]      tot_after;
  logic [CNT_W:0]   cur_inc;
  logic [31:0]      wcnt32, cur32;
  out_item_t        r;

  assign step      = in_valid && !res_full &&
                     (phase_r == PH_COUNT || phase_r == PH_SIZES || phase_r == PH_PAY);
  assign in_pop    = step;
  assign res_push  = step;
  assign word_done = (biw_r == 2'd3);
  assign word      = {in_head.data_byte, asm_r};
  assign sum       = {1'b0, total_r} + {2'b00, word[27:0], 3'b000};
  assign cur_inc   = {1'b0, cur_r} + 1'b1;
  assign wcnt32    = 32'(wcnt_r);
  assign cur32     = 32'(cur_r);

  always_comb begin
    phase_nxt = phase_r;
    asm_nxt   = asm_r;
    biw_nxt   = biw_r;
    count_nxt = count_r;
    wcnt_nxt  = wcnt_r;
    total_nxt = total_r;
    cur_nxt   = cur_r;
    off_nxt   = off_r;
    segb_nxt  = segb_r;
    rd_en     = 1'b0;
    rd_addr   = cur_r[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = wcnt_r[AW-1:0];
    wr_data   = word[27:0];
    done      = 1'b0;
    err       = 1'b0;
    tot_after = total_r;
    r         = '0;
    r.status  = ST_HEADER;

    if (step && (phase_r == PH_COUNT || phase_r == PH_SIZES)) begin
      asm_nxt = asm_r | (24'(in_head.data_byte) << {biw_r, 3'b000});
      biw_nxt = biw_r + 1'b1;
      if (word_done) begin
        asm_nxt = '0;
        biw_nxt = '0;
      end
    end

    unique case (phase_r)
      PH_COUNT: begin
        if (step && word_done) begin
          if (word > 32'(MAX_SEGMENTS - 1)) begin
            r.status = ST_TOO_MANY;
            err      = 1'b1;
          end else begin
            count_nxt = CNT_W'(word + 32'd1);
            wcnt_nxt  = '0;
            total_nxt = '0;
            phase_nxt = PH_SIZES;
          end
        end
      end
      PH_SIZES: begin
        if (step && word_done) begin
          // the word after the last size is padding when the segment count is even
          if (wcnt_r < count_r) begin
            r.segment_index = wcnt32[9:0];
            if (word[31:28] != 4'd0 || sum[32]) begin
              r.status = ST_OVERFLOW;
              err      = 1'b1;
            end else begin
              wr_en           = 1'b1;
              tot_after       = sum[31:0];
              r.size_ready    = 1'b1;
              r.segment_words = word[27:0];
            end
          end
          if (!err) begin
            total_nxt = tot_after;
            if ({1'b0, wcnt_r} + 1'b1 == {1'b0, count_r | CNT_W'(1)}) begin
              if (tot_after == '0) begin
                done = 1'b1;
              end else begin
                phase_nxt = PH_LOAD;
                cur_nxt   = '0;
                off_nxt   = '0;
              end
            end else begin
              wcnt_nxt = wcnt_r + 1'b1;
            end
          end
        end
      end
      PH_LOAD: begin
        rd_en     = 1'b1;
        phase_nxt = PH_CHECK;
      end
      PH_CHECK: begin
        // skip empty segments, but never past the last one
        if (rd_data_r == '0 && cur_inc < {1'b0, count_r}) begin
          cur_nxt = cur_inc[CNT_W-1:0];
          rd_en   = 1'b1;
          rd_addr = cur_inc[AW-1:0];
        end else begin
          segb_nxt  = {rd_data_r, 3'b000};
          phase_nxt = PH_PAY;
        end
      end
      PH_PAY: begin
        if (step) begin
          r.status            = ST_PAYLOAD;
          r.payload_byte      = in_head.data_byte;
          r.segment_index     = cur32[9:0];
          r.offset_in_segment = off_r;
          if ({1'b0, off_r} + 32'd1 >= {1'b0, segb_r}) begin
            r.segment_end = 1'b1;
            cur_nxt       = cur_inc[CNT_W-1:0];
            off_nxt       = '0;
            phase_nxt     = PH_LOAD;
          end else begin
            off_nxt = off_r + 1'b1;
          end
          if (total_r != '0) begin
            tot_after = total_r - 1'b1;
          end
          total_nxt = tot_after;
          if (tot_after == '0) begin
            done = 1'b1;
          end
        end
      end
      default: begin
        phase_nxt = PH_COUNT;
      end
    endcase

    restart = 1'b0;
    if (err) begin
      restart = 1'b1;
    end else if (done) begin
      r.status = ST_DONE;
      restart  = 1'b1;
    end else if (step && in_head.input_ends) begin
      r        = '0;
      r.status = ST_TRUNC;
      restart  = 1'b1;
    end

    if (restart) begin
      phase_nxt = PH_COUNT;
      asm_nxt   = '0;
      biw_nxt   = '0;
      count_nxt = '0;
      wcnt_nxt  = '0;
      total_nxt = '0;
      cur_nxt   = '0;
      off_nxt   = '0;
    end
  end

  assign res_item = r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    segb_r <= segb_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      asm_r   <= '0;
      biw_r   <= '0;
      count_r <= '0;
      wcnt_r  <= '0;
      total_r <= '0;
      cur_r   <= '0;
      off_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      asm_r   <= asm_nxt;
      biw_r   <= biw_nxt;
      count_r <= count_nxt;
      wcnt_r  <= wcnt_nxt;
      total_r <= total_nxt;
      cur_r   <= cur_nxt;
      off_r   <= off_nxt;
    end
  end

endmodule

/* rtl/stdf_out_queue.sv */
module stdf_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  stdf_pkg::out_item_t res_item,
  output logic                res_full,
  output logic                empty,
  input  logic                pop,
  output stdf_pkg::out_item_t out_item
);
  import stdf_pkg::*;

  localparam int PW = (OUT_Q_DEPTH > 1) ? $clog2(OUT_Q_DEPTH) : 1;
  localparam int CW = $clog2(OUT_Q_DEPTH + 1);

  out_item_t       q_r [OUT_Q_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign res_full = (cnt_r == CW'(OUT_Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign out_item = q_r[rp_r];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wp_r] <= res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(OUT_Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(OUT_Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
